[hw/rtl/axafp_pkg.sv]
// shared types and constants of the ax.25 address field parser
`timescale 1ns / 1ps

package axafp_pkg;

    localparam int W_COUNT = 10;
    localparam int W_ROLE  = 3;
    localparam int W_SLOT  = 4;
    localparam int W_CIDX  = 3;
    localparam int W_VALUE = 8;
    localparam int W_SSID  = 4;
    localparam int W_STAT  = 3;
    localparam int W_DIGI  = 4;
    localparam int W_ILEN  = 9;
    localparam int W_FPOS  = 3;
    localparam int W_ODATA = 40;

    localparam logic [W_ROLE-1:0] ROLE_STATUS = 3'd0;
    localparam logic [W_ROLE-1:0] ROLE_CHAR   = 3'd1;
    localparam logic [W_ROLE-1:0] ROLE_SSID   = 3'd2;
    localparam logic [W_ROLE-1:0] ROLE_CTRL   = 3'd3;
    localparam logic [W_ROLE-1:0] ROLE_TYPE   = 3'd4;
    localparam logic [W_ROLE-1:0] ROLE_INFO   = 3'd5;

    localparam logic [W_STAT-1:0] ST_OK        = 3'd0;
    localparam logic [W_STAT-1:0] ST_SHORT     = 3'd1;
    localparam logic [W_STAT-1:0] ST_NO_END    = 3'd2;
    localparam logic [W_STAT-1:0] ST_BAD_LEN   = 3'd3;
    localparam logic [W_STAT-1:0] ST_MANY_DIGI = 3'd4;
    localparam logic [W_STAT-1:0] ST_INFO_LONG = 3'd5;

    localparam logic [W_FPOS-1:0] FPOS_SSID  = 3'd6;
    localparam logic [6:0]        SPACE_CHAR = 7'h20;
    localparam logic [W_COUNT:0]  MIN_FRAME  = 11'd16;
    localparam logic [W_ILEN-1:0] ILEN_LIMIT = 9'd511;

    typedef struct packed {
        logic [W_ROLE-1:0]  role;
        logic [W_SLOT-1:0]  slot;
        logic [W_CIDX-1:0]  char_index;
        logic [W_VALUE-1:0] value;
        logic [W_SSID-1:0]  ssid;
        logic               repeated;
        logic               end_of_frame;
        logic [W_STAT-1:0]  status;
        logic [W_DIGI-1:0]  digi_count;
        logic [W_ILEN-1:0]  info_length;
    } t_result;

endpackage

[hw/rtl/axafp_parse.sv]
// per-byte frame state and result logic of the ax.25 address field parser
`timescale 1ns / 1ps

module axafp_parse #(
    parameter int MAX_DIGIPEATERS = 8,
    parameter int MAX_INFO_BYTES  = 256,
    parameter int MAX_FRAME_BYTES = 1023
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_emit,
    output axafp_pkg::t_result    o_res
);

    localparam int WC = axafp_pkg::W_COUNT;
    localparam logic [WC-1:0] FRAME_MAX = WC'(MAX_FRAME_BYTES);
    localparam logic [WC:0]   INFO_MAX  = (WC+1)'(MAX_INFO_BYTES);
    localparam logic [axafp_pkg::W_SLOT-1:0] SLOT_SHOWN = 4'(MAX_DIGIPEATERS + 1);
    localparam logic [axafp_pkg::W_SLOT-1:0] SLOT_SAT   = 4'(MAX_DIGIPEATERS + 2);
    localparam logic [axafp_pkg::W_DIGI-1:0] DIGI_MAX   = 4'(MAX_DIGIPEATERS);
    localparam int ILEN_CAP_I = (MAX_INFO_BYTES > 511) ? 511 : MAX_INFO_BYTES;
    localparam logic [axafp_pkg::W_ILEN-1:0] ILEN_CAP = 9'(ILEN_CAP_I);

    logic [WC-1:0]                   r_byte_count, n_byte_count;
    logic                            r_addr_done, n_addr_done;
    logic [WC-1:0]                   r_addr_len, n_addr_len;
    logic [axafp_pkg::W_FPOS-1:0]    r_fpos, n_fpos;
    logic [axafp_pkg::W_SLOT-1:0]    r_slot, n_slot;
    logic                            r_space, n_space;
    logic [axafp_pkg::W_STAT-1:0]    r_err, n_err;
    logic [axafp_pkg::W_DIGI-1:0]    r_digis, n_digis;
    logic [1:0]                      r_held_cnt, n_held_cnt;
    logic [7:0]                      r_held [2];
    logic [7:0]                      n_held [2];

    logic [6:0]                      c_char;
    logic [WC:0]                     c_k;
    logic [WC:0]                     c_total;
    logic [WC:0]                     c_alen4;
    logic [WC:0]                     c_ilen;
    logic                            c_emit;
    axafp_pkg::t_result              c_res;

    always_comb begin
        n_byte_count = r_byte_count;
        n_addr_done  = r_addr_done;
        n_addr_len   = r_addr_len;
        n_fpos       = r_fpos;
        n_slot       = r_slot;
        n_space      = r_space;
        n_err        = r_err;
        n_digis      = r_digis;
        n_held_cnt   = r_held_cnt;
        n_held       = r_held;
        c_char       = i_byte[7:1];
        c_k          = {1'b0, r_byte_count} - {1'b0, r_addr_len} - (WC+1)'(4);
        c_emit       = 1'b0;
        c_res        = '0;

        if (r_byte_count >= FRAME_MAX) begin
            if (r_addr_done && r_err == axafp_pkg::ST_OK) begin
                n_err = axafp_pkg::ST_INFO_LONG;
            end
        end else begin
            if (!r_addr_done) begin
                if (r_fpos != axafp_pkg::FPOS_SSID) begin
                    n_space = r_space | (c_char == axafp_pkg::SPACE_CHAR);
                    if (!n_space && r_slot <= SLOT_SHOWN) begin
                        c_res.role       = axafp_pkg::ROLE_CHAR;
                        c_res.slot       = r_slot;
                        c_res.char_index = r_fpos;
                        c_res.value      = {1'b0, c_char};
                        c_emit           = 1'b1;
                    end
                    n_fpos = r_fpos + 3'd1;
                end else begin
                    if (r_slot <= SLOT_SHOWN) begin
                        c_res.role     = axafp_pkg::ROLE_SSID;
                        c_res.slot     = r_slot;
                        c_res.ssid     = i_byte[4:1];
                        c_res.repeated = (r_slot >= 4'd2) ? i_byte[7] : 1'b0;
                        c_emit         = 1'b1;
                    end
                    n_fpos  = '0;
                    n_space = 1'b0;
                    if (r_slot < SLOT_SAT) begin
                        n_slot = r_slot + 4'd1;
                    end
                end
                if (i_byte[0]) begin
                    n_addr_done = 1'b1;
                    n_addr_len  = r_byte_count + WC'(1);
                    if (r_fpos != axafp_pkg::FPOS_SSID || r_slot == '0) begin
                        n_err = axafp_pkg::ST_BAD_LEN;
                    end else begin
                        if (r_slot > SLOT_SHOWN) begin
                            n_err = axafp_pkg::ST_MANY_DIGI;
                        end
                        n_digis = (r_slot - 4'd1 > DIGI_MAX) ? DIGI_MAX : r_slot - 4'd1;
                    end
                end
            end else if (r_byte_count == r_addr_len) begin
                c_res.role  = axafp_pkg::ROLE_CTRL;
                c_res.value = i_byte;
                c_emit      = 1'b1;
            end else if ({1'b0, r_byte_count} == {1'b0, r_addr_len} + (WC+1)'(1)) begin
                c_res.role  = axafp_pkg::ROLE_TYPE;
                c_res.value = i_byte;
                c_emit      = 1'b1;
            end else if (r_held_cnt < 2'd2) begin
                n_held[r_held_cnt[0]] = i_byte;
                n_held_cnt            = r_held_cnt + 2'd1;
            end else begin
                n_held[0] = r_held[1];
                n_held[1] = i_byte;
                if (c_k >= INFO_MAX) begin
                    if (r_err == axafp_pkg::ST_OK) begin
                        n_err = axafp_pkg::ST_INFO_LONG;
                    end
                end else if (r_err != axafp_pkg::ST_INFO_LONG) begin
                    c_res.role  = axafp_pkg::ROLE_INFO;
                    c_res.value = r_held[0];
                    c_emit      = 1'b1;
                end
            end
            n_byte_count = r_byte_count + WC'(1);
        end

        c_res.status = n_err;
        c_total      = {1'b0, n_byte_count};
        c_alen4      = {1'b0, n_addr_len} + (WC+1)'(4);
        c_ilen       = c_total - c_alen4;

        if (i_last) begin
            if (c_res.role != axafp_pkg::ROLE_INFO) begin
                c_res = '0;
            end
            c_res.end_of_frame = 1'b1;
            c_emit             = 1'b1;
            priority if (c_total < axafp_pkg::MIN_FRAME) begin
                c_res.status = axafp_pkg::ST_SHORT;
            end else if (!n_addr_done) begin
                c_res.status = axafp_pkg::ST_NO_END;
            end else if (n_err == axafp_pkg::ST_BAD_LEN || n_err == axafp_pkg::ST_MANY_DIGI) begin
                c_res.status = n_err;
            end else if (c_total < c_alen4) begin
                c_res.status = axafp_pkg::ST_SHORT;
            end else if (n_err == axafp_pkg::ST_INFO_LONG || c_ilen > INFO_MAX) begin
                c_res.status = axafp_pkg::ST_INFO_LONG;
            end else begin
                c_res.status = axafp_pkg::ST_OK;
            end
            c_res.digi_count = (n_addr_done && n_err != axafp_pkg::ST_BAD_LEN) ? n_digis : '0;
            if (n_addr_done && c_total >= c_alen4) begin
                if (n_err == axafp_pkg::ST_INFO_LONG || c_ilen > INFO_MAX) begin
                    c_res.info_length = ILEN_CAP;
                end else if (c_ilen > {2'b00, axafp_pkg::ILEN_LIMIT}) begin
                    c_res.info_length = axafp_pkg::ILEN_LIMIT;
                end else begin
                    c_res.info_length = c_ilen[axafp_pkg::W_ILEN-1:0];
                end
            end
            n_byte_count = '0;
            n_addr_done  = 1'b0;
            n_addr_len   = '0;
            n_fpos       = '0;
            n_slot       = '0;
            n_space      = 1'b0;
            n_err        = axafp_pkg::ST_OK;
            n_digis      = '0;
            n_held_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_addr_done  <= 1'b0;
            r_addr_len   <= '0;
            r_fpos       <= '0;
            r_slot       <= '0;
            r_space      <= 1'b0;
            r_err        <= axafp_pkg::ST_OK;
            r_digis      <= '0;
            r_held_cnt   <= '0;
        end else if (i_fire) begin
            r_byte_count <= n_byte_count;
            r_addr_done  <= n_addr_done;
            r_addr_len   <= n_addr_len;
            r_fpos       <= n_fpos;
            r_slot       <= n_slot;
            r_space      <= n_space;
            r_err        <= n_err;
            r_digis      <= n_digis;
            r_held_cnt   <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

    assign o_emit = c_emit;
    assign o_res  = c_res;

endmodule

[hw/rtl/ax25_address_field_parser_top.sv]
// top level of the ax.25 address field parser
//
// usage:
//   slave channel i_s_*: one frame byte per word, tlast on the final byte
//   (second crc byte). master channel o_m_*: parsed items, tuser is the item
//   role, tlast marks the end-of-frame item that carries the frame status.
//   every item before it is provisional until that status reads ok.
// path: a byte sits in the input register and its item, if any, is written
//   into the output register when the byte is processed; processing waits
//   while an item in the output register is not yet taken.
// throughput: one byte per cycle unless the output stalls; the per-byte
//   counters and flags update in a single pass between the input and output registers.
// reset: synchronous active low, drops both registers and returns the frame
//   state to the start of a frame.
// stall: while i_m_tready is low a waiting item holds; the input register
//   still takes one more byte, then o_s_tready falls until the item is taken.
`timescale 1ns / 1ps

module ax25_address_field_parser_top #(
    parameter int MAX_DIGIPEATERS = 8,
    parameter int MAX_INFO_BYTES  = 256,
    parameter int MAX_FRAME_BYTES = 1023
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // frame_byte [7:0]
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // slot [3:0], char_index [6:4], value [14:7], ssid [18:15], repeated [19],
    // status [22:20], digi_count [26:23], info_length [35:27], zero [39:36]
    output logic [axafp_pkg::W_ODATA-1:0]       o_m_tdata,
    output logic [axafp_pkg::W_ROLE-1:0]        o_m_tuser,   // role [2:0]
    output logic                                o_m_tlast
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    axafp_pkg::t_result r_out;
    logic               c_fire;
    logic               c_emit;
    axafp_pkg::t_result c_res;

    assign c_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || c_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    axafp_parse #(
        .MAX_DIGIPEATERS (MAX_DIGIPEATERS),
        .MAX_INFO_BYTES  (MAX_INFO_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (c_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_emit  (c_emit),
        .o_res   (c_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire) begin
            r_out_valid <= c_emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire && c_emit) begin
            r_out <= c_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.role;
    assign o_m_tlast  = r_out.end_of_frame;
    assign o_m_tdata  = {4'b0000, r_out.info_length, r_out.digi_count, r_out.status,
                         r_out.repeated, r_out.ssid, r_out.value, r_out.char_index,
                         r_out.slot};

    a_eof_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |->
            (o_m_tuser == axafp_pkg::ROLE_STATUS || o_m_tuser == axafp_pkg::ROLE_INFO))
        else $error("end of frame word with wrong role");

    a_summary_only_at_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> r_out.digi_count == '0 && r_out.info_length == '0)
        else $error("frame summary on a non-final word");

    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(c_fire) && $past(c_emit))
        else $error("output word appeared without a processed byte");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_fire && r_in_last |-> c_emit)
        else $error("final byte produced no word");

endmodule
